// ===== src/psu_pkg.sv =====
// psu_pkg: shared types and constants for the png scanline unfilter unit
// holds the item descriptor passed from the position tracker to the reconstruction stage
// no dependencies
package psu_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_COLOR_MODE   = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // configuration reset values
  localparam logic [1:0]  COLOR_MODE_RST   = 2'd1;
  localparam logic [10:0] IMAGE_WIDTH_RST  = 11'd1;
  localparam logic [10:0] IMAGE_HEIGHT_RST = 11'd1;

  // color modes
  localparam logic [1:0] MODE_GREY  = 2'd0;
  localparam logic [1:0] MODE_RGB   = 2'd1;
  localparam logic [1:0] MODE_GREYA = 2'd2;
  localparam logic [1:0] MODE_RGBA  = 2'd3;

  // row filter types
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // what an accepted byte turns out to be
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FILTER,
    KIND_BAD,
    KIND_SAMPLE
  } kind_t;

  // per-byte descriptor from the tracker to the reconstruction stage
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  filter;
    logic        first_row;
    logic        has_left;
    logic [1:0]  lane;
    logic        grey;
    logic        emit;
    logic        row_done;
    logic        image_done;
    logic        restart;
    logic [9:0]  column;
    logic [9:0]  row;
  } desc_t;

endpackage

// ===== src/psu_ram.sv =====
// psu_ram: generic single write port, single read port memory
// read data is registered; no dependencies
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/psu_tracker.sv =====
// psu_tracker: row and byte position tracking for the unfilter unit
// classifies each accepted byte and issues the row store read; uses psu_pkg
module psu_tracker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int LINE_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    color_mode,
  input  logic [10:0]                   image_width,
  input  logic [10:0]                   image_height,
  input  logic                          accept,
  input  logic [7:0]                    data_byte,
  input  logic                          image_start,
  output psu_pkg::desc_t                desc,
  output logic [$clog2(LINE_BYTES)-1:0] pos,
  output logic                          rd_en
);

  localparam int PW  = $clog2(LINE_BYTES);
  localparam int LW  = $clog2(LINE_BYTES + 1);
  localparam int MW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int XW0 = (MW > LW) ? MW : LW;
  localparam int XW  = (XW0 > 11) ? XW0 : 11;
  localparam int HX  = (HW > 11) ? HW : 11;
  localparam int S3  = PW + 2;
  localparam logic [PW:0] RECIP3 = (PW + 1)'((2 ** S3 + 2) / 3);
  localparam logic [XW-1:0] CAP1 = XW'(LINE_BYTES);
  localparam logic [XW-1:0] CAP2 = XW'(LINE_BYTES / 2);
  localparam logic [XW-1:0] CAP3 = XW'(LINE_BYTES / 3);
  localparam logic [XW-1:0] CAP4 = XW'(LINE_BYTES / 4);

  // position state
  logic          halted;
  logic          awaiting;
  logic          first_row;
  logic [PW-1:0] byte_pos;
  logic [HW-1:0] row_cnt;
  logic [2:0]    filter;

  logic          halted_next;
  logic          awaiting_next;
  logic          first_row_next;
  logic [PW-1:0] byte_pos_next;
  logic [HW-1:0] row_cnt_next;
  logic [2:0]    filter_next;

  // values seen after an image restart
  logic          st_halt;
  logic          st_await;
  logic          st_first;
  logic [PW-1:0] st_pos;
  logic [HW-1:0] st_row;

  // geometry
  logic [2:0]      bpp;
  logic [XW-1:0]   cap;
  logic [XW-1:0]   width_x;
  logic [LW-1:0]   width_eff;
  logic [LW+1:0]   line_len;
  logic [HX-1:0]   height_eff;

  // byte position decode
  logic [2*PW:0]   prod3;
  logic [PW-2:0]   q3;
  logic [PW-1:0]   r3;
  logic [1:0]      lane;
  logic [PW-1:0]   col_full;
  logic            last_in_row;
  logic            pix_end;
  logic [HW:0]     row_inc;
  logic            last_in_image;

  // restart view of the state
  always_comb begin
    st_halt  = image_start ? 1'b0 : halted;
    st_await = image_start ? 1'b1 : awaiting;
    st_first = image_start ? 1'b1 : first_row;
    st_pos   = image_start ? '0 : byte_pos;
    st_row   = image_start ? '0 : row_cnt;
  end

  // effective row length and image height
  always_comb begin
    unique case (color_mode)
      psu_pkg::MODE_GREY:  begin bpp = 3'd1; cap = CAP1; end
      psu_pkg::MODE_RGB:   begin bpp = 3'd3; cap = CAP3; end
      psu_pkg::MODE_GREYA: begin bpp = 3'd2; cap = CAP2; end
      default:             begin bpp = 3'd4; cap = CAP4; end
    endcase
    width_x = XW'(image_width);
    if (width_x == '0) begin
      width_x = XW'(1);
    end
    if (width_x > XW'(MAX_WIDTH)) begin
      width_x = XW'(MAX_WIDTH);
    end
    if (width_x > cap) begin
      width_x = cap;
    end
    width_eff = LW'(width_x);
    unique case (color_mode)
      psu_pkg::MODE_GREY:  line_len = (LW + 2)'(width_eff);
      psu_pkg::MODE_RGB:   line_len = (LW + 2)'(width_eff) + ((LW + 2)'(width_eff) << 1);
      psu_pkg::MODE_GREYA: line_len = (LW + 2)'(width_eff) << 1;
      default:             line_len = (LW + 2)'(width_eff) << 2;
    endcase
    height_eff = HX'(image_height);
    if (height_eff == '0) begin
      height_eff = HX'(1);
    end
    if (height_eff > HX'(MAX_HEIGHT)) begin
      height_eff = HX'(MAX_HEIGHT);
    end
  end

  // lane and pixel column of the current byte; divide by three via reciprocal
  always_comb begin
    prod3 = (2 * PW + 1)'(st_pos) * (2 * PW + 1)'(RECIP3);
    q3    = prod3[2*PW:S3];
    r3    = st_pos - PW'((PW + 2)'(q3) * (PW + 2)'(3));
    unique case (color_mode)
      psu_pkg::MODE_GREY:  begin lane = 2'd0;          col_full = st_pos;      end
      psu_pkg::MODE_RGB:   begin lane = r3[1:0];       col_full = PW'(q3);     end
      psu_pkg::MODE_GREYA: begin lane = {1'b0, st_pos[0]}; col_full = st_pos >> 1; end
      default:             begin lane = st_pos[1:0];   col_full = st_pos >> 2; end
    endcase
    last_in_row   = ((LW + 2)'(st_pos) + (LW + 2)'(1)) >= line_len;
    pix_end       = (3'(lane) + 3'd1) == bpp;
    row_inc       = (HW + 1)'(st_row) + (HW + 1)'(1);
    last_in_image = (HX + 1)'(row_inc) >= (HX + 1)'(height_eff);
  end

  // byte classification and next state
  always_comb begin
    halted_next    = st_halt;
    awaiting_next  = st_await;
    first_row_next = st_first;
    byte_pos_next  = st_pos;
    row_cnt_next   = st_row;
    filter_next    = filter;

    desc            = '0;
    desc.kind       = psu_pkg::KIND_NONE;
    desc.filter     = filter;
    desc.first_row  = st_first;
    desc.has_left   = (PW + 3)'(st_pos) >= (PW + 3)'(bpp);
    desc.lane       = lane;
    desc.grey       = ~color_mode[0];
    desc.restart    = image_start;
    desc.column     = 10'(col_full);
    desc.row        = 10'(st_row);

    if (!st_halt) begin
      if (st_await) begin
        if (data_byte > 8'd4) begin
          desc.kind   = psu_pkg::KIND_BAD;
          halted_next = 1'b1;
        end else begin
          desc.kind     = psu_pkg::KIND_FILTER;
          filter_next   = data_byte[2:0];
          awaiting_next = 1'b0;
          byte_pos_next = '0;
        end
      end else begin
        desc.kind     = psu_pkg::KIND_SAMPLE;
        desc.emit     = last_in_row | pix_end;
        desc.row_done = last_in_row;
        if (last_in_row) begin
          row_cnt_next    = HW'(row_inc);
          first_row_next  = 1'b0;
          awaiting_next   = 1'b1;
          byte_pos_next   = '0;
          desc.image_done = last_in_image;
          halted_next     = last_in_image;
        end else begin
          byte_pos_next = st_pos + PW'(1);
        end
      end
    end

    pos   = st_pos;
    rd_en = accept & (desc.kind == psu_pkg::KIND_SAMPLE) & ~st_first;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      halted    <= 1'b0;
      awaiting  <= 1'b1;
      first_row <= 1'b1;
      byte_pos  <= '0;
      row_cnt   <= '0;
      filter    <= psu_pkg::FILT_NONE;
    end else if (accept) begin
      halted    <= halted_next;
      awaiting  <= awaiting_next;
      first_row <= first_row_next;
      byte_pos  <= byte_pos_next;
      row_cnt   <= row_cnt_next;
      filter    <= filter_next;
    end
  end

endmodule

// ===== src/psu_recon.sv =====
// psu_recon: byte reconstruction stage and output register of the unfilter unit
// applies the row filter with the row store read data and writes back; uses psu_pkg
module psu_recon #(
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  psu_pkg::desc_t      desc,
  input  logic [ADDR_W-1:0]   pos,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          rd_data,
  output logic                wr_en,
  output logic [ADDR_W-1:0]   wr_addr,
  output logic [7:0]          wr_data,
  output logic                busy,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [9:0]          pixel_column,
  output logic [9:0]          pixel_row,
  output logic                row_done,
  output logic                image_done,
  output logic                bad_filter
);

  // stage registers, filled in the cycle the row store is read
  logic              s1_valid;
  psu_pkg::desc_t    s1_desc;
  logic [ADDR_W-1:0] s1_pos;
  logic [7:0]        s1_data;

  // neighbor bytes, one per lane, and the pixel being assembled
  logic [7:0] left [4];
  logic [7:0] upper [4];
  logic [7:0] ch_r;
  logic [7:0] ch_g;
  logic [7:0] ch_b;
  logic [7:0] ch_r_next;
  logic [7:0] ch_g_next;
  logic [7:0] ch_b_next;

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] c;
  logic [8:0] avg_sum;
  logic [7:0] pred;
  logic [7:0] val;
  logic       has_result;
  logic       s1_go;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic signed [10:0] p;
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0] ma;
    logic [9:0] mb;
    logic [9:0] mc;
    p  = $signed({3'b0, pa_a}) + $signed({3'b0, pa_b}) - $signed({3'b0, pa_c});
    da = p - $signed({3'b0, pa_a});
    db = p - $signed({3'b0, pa_b});
    dc = p - $signed({3'b0, pa_c});
    ma = (da < 0) ? 10'(-da) : 10'(da);
    mb = (db < 0) ? 10'(-db) : 10'(db);
    mc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (ma <= mb && ma <= mc) begin
      return pa_a;
    end
    return (mb <= mc) ? pa_b : pa_c;
  endfunction

  // neighbors and prediction
  always_comb begin
    a = s1_desc.has_left ? left[s1_desc.lane] : 8'd0;
    b = s1_desc.first_row ? 8'd0 : rd_data;
    c = (s1_desc.has_left && !s1_desc.first_row) ? upper[s1_desc.lane] : 8'd0;
    avg_sum = {1'b0, a} + {1'b0, b};
    unique case (s1_desc.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred = paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
    val = s1_data + pred;
  end

  // pixel assembly: grey fills all three channels, alpha lane is dropped
  always_comb begin
    ch_r_next = ch_r;
    ch_g_next = ch_g;
    ch_b_next = ch_b;
    if (s1_desc.kind == psu_pkg::KIND_SAMPLE) begin
      if (s1_desc.grey) begin
        if (s1_desc.lane == 2'd0) begin
          ch_r_next = val;
          ch_g_next = val;
          ch_b_next = val;
        end
      end else begin
        unique case (s1_desc.lane)
          2'd0:    ch_r_next = val;
          2'd1:    ch_g_next = val;
          2'd2:    ch_b_next = val;
          default: ch_r_next = ch_r;
        endcase
      end
    end else if (s1_desc.restart) begin
      ch_r_next = 8'd0;
      ch_g_next = 8'd0;
      ch_b_next = 8'd0;
    end
  end

  // stage advance: a result needs room in the output register
  always_comb begin
    has_result = (s1_desc.kind == psu_pkg::KIND_BAD) ||
                 (s1_desc.kind == psu_pkg::KIND_SAMPLE && s1_desc.emit);
    s1_go   = s1_valid & (~has_result | ~out_valid | ~out_stall);
    busy    = s1_valid & ~s1_go;
    wr_en   = s1_go & (s1_desc.kind == psu_pkg::KIND_SAMPLE);
    wr_addr = s1_pos;
    wr_data = val;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (desc.kind != psu_pkg::KIND_NONE);
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_desc <= desc;
      s1_pos  <= pos;
      s1_data <= data_byte;
    end
  end

  // neighbor bytes and pixel channels
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        left[i]  <= 8'd0;
        upper[i] <= 8'd0;
      end
      ch_r <= 8'd0;
      ch_g <= 8'd0;
      ch_b <= 8'd0;
    end else if (s1_go) begin
      ch_r <= ch_r_next;
      ch_g <= ch_g_next;
      ch_b <= ch_b_next;
      if (s1_desc.kind == psu_pkg::KIND_FILTER) begin
        for (int i = 0; i < 4; i++) begin
          left[i]  <= 8'd0;
          upper[i] <= 8'd0;
        end
      end else if (s1_desc.kind == psu_pkg::KIND_SAMPLE) begin
        left[s1_desc.lane]  <= val;
        upper[s1_desc.lane] <= b;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      pixel_row <= s1_desc.row;
      if (s1_desc.kind == psu_pkg::KIND_BAD) begin
        red          <= 8'd0;
        green        <= 8'd0;
        blue         <= 8'd0;
        pixel_column <= 10'd0;
        row_done     <= 1'b0;
        image_done   <= 1'b0;
        bad_filter   <= 1'b1;
      end else begin
        red          <= ch_r_next;
        green        <= ch_g_next;
        blue         <= ch_b_next;
        pixel_column <= s1_desc.column;
        row_done     <= s1_desc.row_done;
        image_done   <= s1_desc.image_done;
        bad_filter   <= 1'b0;
      end
    end
  end

endmodule

// ===== src/png_scanline_unfilter_to_rgb_unit.sv =====
// png_scanline_unfilter_to_rgb_unit: top level of the png scanline unfilter unit
// depends on psu_pkg, psu_ram, psu_tracker and psu_recon
//
//   port group    dir   handshake             payload
//   in            in    in_valid / in_stall   data_byte, image_start
//   out           out   out_valid / out_stall red, green, blue, pixel_column, pixel_row,
//                                             row_done, image_done, bad_filter
//   cfg           in    cfg_write             cfg_index, cfg_data
//
// one byte per cycle while in_stall is low; a result passes the stage register, then the output register
// the row store is read when a byte is taken and written back when the byte leaves the stage
// reset clears position state and neighbors; the row store is not cleared
// in_stall rises only when a result waits in the stage behind a full, stalled output
module png_scanline_unfilter_to_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int LINE_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        image_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [9:0]  pixel_column,
  output logic [9:0]  pixel_row,
  output logic        row_done,
  output logic        image_done,
  output logic        bad_filter
);

  localparam int AW = $clog2(LINE_BYTES);

  logic [1:0]     color_mode;
  logic [10:0]    image_width;
  logic [10:0]    image_height;
  logic           accept;
  psu_pkg::desc_t desc;
  logic [AW-1:0]  rd_addr;
  logic           rd_en;
  logic [7:0]     rd_data;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic           busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode   <= psu_pkg::COLOR_MODE_RST;
      image_width  <= psu_pkg::IMAGE_WIDTH_RST;
      image_height <= psu_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        psu_pkg::REG_COLOR_MODE:   color_mode   <= cfg_data[1:0];
        psu_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        psu_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:                   color_mode   <= color_mode;
      endcase
    end
  end

  // input handshake
  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  psu_tracker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .LINE_BYTES (LINE_BYTES)
  ) u_tracker (
    .clk          (clk),
    .rst          (rst),
    .color_mode   (color_mode),
    .image_width  (image_width),
    .image_height (image_height),
    .accept       (accept),
    .data_byte    (data_byte),
    .image_start  (image_start),
    .desc         (desc),
    .pos          (rd_addr),
    .rd_en        (rd_en)
  );

  // previous row store
  psu_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  psu_recon #(
    .ADDR_W (AW)
  ) u_recon (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .desc         (desc),
    .pos          (rd_addr),
    .data_byte    (data_byte),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .busy         (busy),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .row_done     (row_done),
    .image_done   (image_done),
    .bad_filter   (bad_filter)
  );

endmodule
